// ===== rtl/twsd_pkg.sv =====
// Shared constants, types and register codes of the time-window spike detector.
`timescale 1ns / 1ps
`default_nettype none
package twsd_pkg;

  localparam int DEFAULT_RING_DEPTH = 64;

  localparam int STAMP_W  = 32;
  localparam int VALUE_W  = 16;
  localparam int WINDOW_W = 16;
  localparam int RATIO_W  = 8;
  localparam int HELD_W   = 7;
  localparam int TOTAL_W  = 22;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd5;
  localparam logic [RATIO_W-1:0]  RATIO_RESET  = 8'd2;

  typedef enum logic {
    REG_WINDOW_DURATION = 1'b0,
    REG_SPIKE_RATIO     = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [VALUE_W-1:0] value;
  } ring_entry_t;

endpackage
`default_nettype wire

// ===== rtl/twsd_ring.sv =====
// Sample ring storage: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module twsd_ring #(
  parameter int RING_DEPTH = twsd_pkg::DEFAULT_RING_DEPTH,
  localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [PTR_W-1:0]      wr_addr,
  input  wire twsd_pkg::ring_entry_t wr_data,
  input  wire logic                  rd_en,
  input  wire logic [PTR_W-1:0]      rd_addr,
  output twsd_pkg::ring_entry_t      rd_data
);
  import twsd_pkg::*;

  ring_entry_t mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/time_window_spike_detector.sv =====
// Top level of the time-window spike detector: control, window state and APB registers.
`timescale 1ns / 1ps
`default_nettype none
//
// Channel   Handshake                    Payload
// sample    sample_valid / sample_ready  sample_time, sample_value
// result    result_valid / result_ready  spike, entries_held, window_total, dropped_full
// config    APB psel / penable / pready  paddr, pwdata, prdata
//
// A sample passes through ST_EVICT, which retires the samples that age out of the window
// one at a time through the single read port of the ring, then writes the new one, and ST_RESULT.
// Reset is synchronous and clears the window; ring contents are not cleared.
// A new sample is taken while an earlier result waits in the output register; the
// block holds in its final step only if that register is still occupied.
module time_window_spike_detector #(
  parameter int RING_DEPTH = twsd_pkg::DEFAULT_RING_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [twsd_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [twsd_pkg::DATA_W-1:0]     pwdata,
  output logic      [twsd_pkg::DATA_W-1:0]     prdata,
  output logic                                 pready,
  input  wire logic                            sample_valid,
  output logic                                 sample_ready,
  input  wire logic [twsd_pkg::STAMP_W-1:0]    sample_time,
  input  wire logic [twsd_pkg::VALUE_W-1:0]    sample_value,
  output logic                                 result_valid,
  input  wire logic                            result_ready,
  output logic                                 spike,
  output logic      [twsd_pkg::HELD_W-1:0]     entries_held,
  output logic      [twsd_pkg::TOTAL_W-1:0]    window_total,
  output logic                                 dropped_full
);
  import twsd_pkg::*;

  localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int TOT_W  = VALUE_W + CNT_W;
  localparam int PROD_W = RATIO_W + TOT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVICT,
    ST_RESULT
  } state_t;

  state_t                state;
  logic [PTR_W-1:0]      oldest_slot;
  logic [CNT_W-1:0]      held_count;
  logic [TOT_W-1:0]      running_total;
  logic [STAMP_W-1:0]    cur_time;
  logic [VALUE_W-1:0]    cur_value;
  logic                  cur_dropped;
  logic [WINDOW_W-1:0]   window_duration;
  logic [RATIO_W-1:0]    spike_ratio;

  ring_entry_t           rd_entry;
  ring_entry_t           wr_entry;
  logic                  rd_en;
  logic [PTR_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [PTR_W-1:0]      wr_slot;

  logic [PTR_W-1:0]      oldest_inc;
  logic [SUM_W-1:0]      slot_sum;
  logic                  expired;
  logic                  pop;
  logic                  full;
  logic                  take_sample;
  logic                  out_free;
  logic [PROD_W-1:0]     prod_new;
  logic [PROD_W-1:0]     prod_ref;
  logic                  spike_next;
  logic [CNT_W+HELD_W-1:0]   held_wide;
  logic [TOT_W+TOTAL_W-1:0]  total_wide;

  assign pready       = 1'b1;
  assign sample_ready = (state == ST_IDLE);
  assign take_sample  = sample_valid && sample_ready;
  assign out_free     = !result_valid || result_ready;

  assign oldest_inc = (oldest_slot == PTR_W'(RING_DEPTH - 1)) ? '0 : oldest_slot + 1'b1;
  assign slot_sum   = SUM_W'(oldest_slot) + SUM_W'(held_count);
  assign wr_slot    = (slot_sum >= SUM_W'(RING_DEPTH)) ?
                      PTR_W'(slot_sum - SUM_W'(RING_DEPTH)) : PTR_W'(slot_sum);

  assign expired = ({1'b0, rd_entry.stamp} + (STAMP_W+1)'(window_duration))
                   <= {1'b0, cur_time};
  assign pop     = (state == ST_EVICT) && (held_count != '0) && expired;
  assign full    = (held_count == CNT_W'(RING_DEPTH));

  assign rd_en   = take_sample || pop;
  assign rd_addr = take_sample ? oldest_slot : oldest_inc;
  assign wr_en   = (state == ST_EVICT) && !pop;
  assign wr_entry.stamp = cur_time;
  assign wr_entry.value = cur_value;

  assign prod_new   = PROD_W'(cur_value) * PROD_W'(held_count);
  assign prod_ref   = PROD_W'(spike_ratio) * PROD_W'(running_total);
  assign spike_next = (held_count >= CNT_W'(2)) && (prod_new > prod_ref);

  assign held_wide  = {{HELD_W{1'b0}}, held_count};
  assign total_wide = {{TOTAL_W{1'b0}}, running_total};

  twsd_ring #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_slot),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      oldest_slot   <= '0;
      held_count    <= '0;
      running_total <= '0;
      result_valid  <= 1'b0;
      cur_dropped   <= 1'b0;
    end else begin
      if (result_valid && result_ready && (state != ST_RESULT)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (take_sample) begin
            cur_time    <= sample_time;
            cur_value   <= sample_value;
            cur_dropped <= 1'b0;
            state       <= ST_EVICT;
          end
        end
        ST_EVICT: begin
          if (pop) begin
            running_total <= running_total - TOT_W'(rd_entry.value);
            oldest_slot   <= oldest_inc;
            held_count    <= held_count - 1'b1;
          end else begin
            if (full) begin
              running_total <= running_total - TOT_W'(rd_entry.value) + TOT_W'(cur_value);
              oldest_slot   <= oldest_inc;
              cur_dropped   <= 1'b1;
            end else begin
              running_total <= running_total + TOT_W'(cur_value);
              held_count    <= held_count + 1'b1;
            end
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            spike        <= spike_next;
            entries_held <= held_wide[HELD_W-1:0];
            window_total <= total_wide[TOTAL_W-1:0];
            dropped_full <= cur_dropped;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_duration <= WINDOW_RESET;
      spike_ratio     <= RATIO_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_index_t'(paddr[2]))
        REG_WINDOW_DURATION: window_duration <= pwdata[WINDOW_W-1:0];
        REG_SPIKE_RATIO:     spike_ratio     <= pwdata[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index_t'(paddr[2]))
      REG_WINDOW_DURATION: prdata = {{(DATA_W-WINDOW_W){1'b0}}, window_duration};
      REG_SPIKE_RATIO:     prdata = {{(DATA_W-RATIO_W){1'b0}}, spike_ratio};
      default:             prdata = '0;
    endcase
  end

endmodule
`default_nettype wire
